// ----- rtl/sha_pkg.sv -----
// SHA-256 stream hasher package: controller/datapath command and status types,
// FSM state type, round constants, initial hash values and round functions.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

	localparam logic [1:0] MODE_DATA    = 2'd0;
	localparam logic [1:0] MODE_FINISH  = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FINISHED = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_DATA,
		SEL_MARK,
		SEL_PAD
	} byte_sel_t;

	typedef struct packed {
		logic       shift_byte;
		byte_sel_t  byte_sel;
		logic       start_pad;
		logic       load;
		logic       round;
		logic       fold;
		logic       fold_pad;
		logic       emit_load;
		logic       err_load;
		logic [1:0] err_code;
		logic       set_done;
		logic       restart;
	} cmd_t;

	typedef struct packed {
		logic fill_full;
		logic done;
		logic at_limit;
		logic lenphase;
		logic round_last;
		logic emit_last;
		logic out_free;
	} stat_t;

	function automatic logic [31:0] round_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'h428A2F98; 6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hB5C0FBCF; 6'd3:  k = 32'hE9B5DBA5;
			6'd4:  k = 32'h3956C25B; 6'd5:  k = 32'h59F111F1;
			6'd6:  k = 32'h923F82A4; 6'd7:  k = 32'hAB1C5ED5;
			6'd8:  k = 32'hD807AA98; 6'd9:  k = 32'h12835B01;
			6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
			6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
			6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
			6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
			6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
			6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
			6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
			6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
			6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
			6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
			6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
			6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
			6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
			6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
			6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
			6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
			6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
			6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
			6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
			6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
			6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
			6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
			6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
			6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
			6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
			6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
			6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] h;
		case (i)
			3'd0: h = 32'h6A09E667;
			3'd1: h = 32'hBB67AE85;
			3'd2: h = 32'h3C6EF372;
			3'd3: h = 32'hA54FF53A;
			3'd4: h = 32'h510E527F;
			3'd5: h = 32'h9B05688C;
			3'd6: h = 32'h1F83D9AB;
			3'd7: h = 32'h5BE0CD19;
			default: h = 32'h0;
		endcase
		return h;
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ----- rtl/sha256_stream_hasher_core.sv -----
// SHA-256 stream hasher, top level: joins the controller and the datapath.
// Depends on sha_pkg, sha_ctrl and sha_datapath.
`timescale 1ns / 1ps

// Streaming SHA-256. Each input transaction carries a mode in s_tuser (append byte,
// finish, restart) and a message byte in s_tdata[7:0]. An appended byte is shifted
// into the block line; the byte that fills a 64-byte block starts the compression
// (a load, 64 rounds through a single round unit, a fold). A finish shifts padding
// in one byte a cycle up to the end of the block, and through a second block when
// the length spills into it, then compresses one or two blocks and returns eight
// digest words, most significant first, one per output transaction, with tlast on
// the eighth. A data or finish transaction after a finish, or a byte past the
// length limit, returns a single error word with tlast set. Input is taken only
// while no work is in flight and the output register is free or being emptied.
module sha256_stream_hasher_core import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] data_byte
	input  logic [1:0]  s_tuser,  // [1:0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
	output logic        m_tlast,  // last_word
	output logic [1:0]  m_tuser   // [1:0] status
);

	cmd_t  cmd;
	stat_t stat;

	sha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.mode     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sha_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_byte (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

// ----- rtl/sha_ctrl.sv -----
// SHA-256 stream hasher controller: sequences byte intake, padding, the
// 64 rounds, chaining fold and digest emission. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_ctrl import sha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] mode,
	output logic       s_tready,
	input  stat_t      stat,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	logic   pad_q, pad_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pad_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			pad_q   <= pad_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		pad_d   = pad_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !stat.done) begin
					if (mode == MODE_DATA && !stat.at_limit && stat.fill_full)
						state_d = ST_LOAD;
					else if (mode == MODE_FINISH) begin
						pad_d   = 1'b1;
						state_d = stat.fill_full ? ST_LOAD : ST_PAD;
					end
				end
			end
			ST_PAD:   if (stat.fill_full) state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_ROUND;
			ST_ROUND: if (stat.round_last) state_d = ST_FOLD;
			ST_FOLD: begin
				if (!pad_q)
					state_d = ST_IDLE;
				else if (stat.lenphase) begin
					pad_d   = 1'b0;
					state_d = ST_EMIT;
				end else
					state_d = ST_PAD;
			end
			ST_EMIT:  if (stat.out_free && stat.emit_last) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		cmd.byte_sel = SEL_DATA;
		cmd.err_code = STATUS_OK;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_RESTART)
						cmd.restart = 1'b1;
					else if (mode == MODE_DATA || mode == MODE_FINISH) begin
						if (stat.done) begin
							cmd.err_load = 1'b1;
							cmd.err_code = STATUS_FINISHED;
						end else if (mode == MODE_DATA) begin
							if (stat.at_limit) begin
								cmd.err_load = 1'b1;
								cmd.err_code = STATUS_OVERFLOW;
							end else
								cmd.shift_byte = 1'b1;
						end else begin
							cmd.shift_byte = 1'b1;
							cmd.byte_sel   = SEL_MARK;
							cmd.start_pad  = 1'b1;
						end
					end
				end
			end
			ST_PAD: begin
				cmd.shift_byte = 1'b1;
				cmd.byte_sel   = SEL_PAD;
			end
			ST_LOAD:  cmd.load  = 1'b1;
			ST_ROUND: cmd.round = 1'b1;
			ST_FOLD: begin
				cmd.fold     = 1'b1;
				cmd.fold_pad = pad_q;
			end
			ST_EMIT: begin
				if (stat.out_free) begin
					cmd.emit_load = 1'b1;
					cmd.set_done  = stat.emit_last;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- rtl/sha_datapath.sv -----
// SHA-256 stream hasher datapath: block shift line, message schedule window,
// round unit, chaining words, counters and the output register. Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_datapath import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  data_byte,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        m_tready,
	output logic        m_tvalid,
	output logic [39:0] m_tdata,
	output logic        m_tlast,
	output logic [1:0]  m_tuser
);

	logic [511:0] blk_q;
	logic [31:0]  w_q [16];
	logic [31:0]  work_q [8];
	logic [31:0]  h_q [8];
	logic [5:0]   round_q;
	logic [5:0]   fill_q;
	logic [60:0]  total_q;
	logic         done_q;
	logic         lenphase_q;
	logic [2:0]   idx_q;
	logic         out_valid_q;
	logic [31:0]  out_word_q;
	logic [2:0]   out_idx_q;
	logic         out_last_q;
	logic [1:0]   out_status_q;

	logic [7:0]   in_byte;
	logic [63:0]  len_bits;
	logic [31:0]  t1, t2, w_new;
	logic         out_free;

	assign len_bits = {total_q, 3'b000};
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: in_byte = data_byte;
			SEL_MARK: in_byte = PAD_MARK;
			SEL_PAD:  in_byte = (lenphase_q && fill_q >= LEN_POS) ?
			                    len_bits[{~fill_q[2:0], 3'b000} +: 8] : 8'h00;
			default:  in_byte = 8'h00;
		endcase
	end

	always_comb begin
		t1 = work_q[7] + big_sig1(work_q[4]) +
		     ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6])) +
		     round_k(round_q) + w_q[0];
		t2 = big_sig0(work_q[0]) +
		     ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
		w_new = w_q[0] + small_sig0(w_q[1]) + w_q[9] + small_sig1(w_q[14]);
	end

	// payload: block line, schedule window, working variables
	always_ff @(posedge clk) begin
		if (cmd.shift_byte)
			blk_q <= {blk_q[503:0], in_byte};
		if (cmd.load) begin
			for (int j = 0; j < 16; j++)
				w_q[j] <= blk_q[511 - 32 * j -: 32];
			for (int j = 0; j < 8; j++)
				work_q[j] <= h_q[j];
		end else if (cmd.round) begin
			for (int j = 0; j < 15; j++)
				w_q[j] <= w_q[j + 1];
			w_q[15] <= w_new;
			work_q[0] <= t1 + t2;
			work_q[1] <= work_q[0];
			work_q[2] <= work_q[1];
			work_q[3] <= work_q[2];
			work_q[4] <= work_q[3] + t1;
			work_q[5] <= work_q[4];
			work_q[6] <= work_q[5];
			work_q[7] <= work_q[6];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_load) begin
			out_word_q   <= h_q[idx_q];
			out_idx_q    <= idx_q;
			out_last_q   <= (idx_q == 3'd7);
			out_status_q <= STATUS_OK;
		end else if (cmd.err_load) begin
			out_word_q   <= 32'h0;
			out_idx_q    <= 3'd0;
			out_last_q   <= 1'b1;
			out_status_q <= cmd.err_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++)
				h_q[j] <= init_h(3'(j));
			round_q     <= '0;
			fill_q      <= '0;
			total_q     <= '0;
			done_q      <= 1'b0;
			lenphase_q  <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.restart) begin
				for (int j = 0; j < 8; j++)
					h_q[j] <= init_h(3'(j));
				fill_q  <= '0;
				total_q <= '0;
				done_q  <= 1'b0;
			end
			if (cmd.shift_byte) begin
				fill_q <= fill_q + 6'd1;
				if (cmd.byte_sel == SEL_DATA)
					total_q <= total_q + 61'd1;
			end
			// length bytes go in this block only if the marker left room for them
			if (cmd.start_pad)
				lenphase_q <= (fill_q < LEN_POS);
			if (cmd.load)
				round_q <= '0;
			else if (cmd.round)
				round_q <= round_q + 6'd1;
			if (cmd.fold) begin
				for (int j = 0; j < 8; j++)
					h_q[j] <= h_q[j] + work_q[j];
				if (cmd.fold_pad)
					lenphase_q <= 1'b1;
			end
			if (cmd.emit_load)
				idx_q <= idx_q + 3'd1;
			if (cmd.set_done)
				done_q <= 1'b1;
			if (cmd.emit_load || cmd.err_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign stat.fill_full  = (fill_q == 6'd63);
	assign stat.done       = done_q;
	assign stat.at_limit   = &total_q;
	assign stat.lenphase   = lenphase_q;
	assign stat.round_last = (round_q == 6'd63);
	assign stat.emit_last  = (idx_q == 3'd7);
	assign stat.out_free   = out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b00000, out_idx_q, out_word_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_status_q;

endmodule

// ----- rtl/sha_checker.sv -----
// SHA-256 stream hasher port checker and its bind to the top level.
// Depends on sha_pkg and sha256_stream_hasher_core.
`timescale 1ns / 1ps

module sha_checker import sha_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic [1:0]  m_tuser
);

	// hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STATUS_OK |-> m_tlast && m_tdata == 40'h0)
		else $error("error result not a single zero word");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_OK |-> m_tlast == (m_tdata[34:32] == 3'd7))
		else $error("tlast not on the eighth digest word");

	// digest words leave in order
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser == STATUS_OK && !m_tlast |=>
		m_tvalid && m_tuser == STATUS_OK && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1)
		else $error("digest word out of sequence");

endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ----- test/sha256_stream_hasher_core_tb.sv -----
// Self-checking testbench for the streaming SHA-256 hasher core.
// Drives byte, finish and restart transactions with random gaps and output stalls,
// and checks every digest word against an in-bench SHA-256 predictor. Uses sha_pkg.
`timescale 1ns / 1ps

module sha256_stream_hasher_core_tb;
	import sha_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] data;
		bit         has_word;  // first expected word typed in
		logic [31:0] word0;
		logic [1:0]  status0;
	} stim_row_t;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
		logic [1:0]  status;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	// predictor state
	logic [31:0] hash_state [8];
	logic [7:0]  msg_block [64];
	int unsigned block_fill;
	logic [60:0] msg_bytes;
	bit          hash_done;

	digest_beat_t pending_beats [$];
	stim_row_t    directed_rows [$];
	int           mismatches;
	int           cycle_count;

	sha256_stream_hasher_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		return (v >> n) | (v << (32 - n));
	endfunction

	localparam logic [31:0] ROUND_CONST [64] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5, 32'h3956C25B, 32'h59F111F1,
		32'h923F82A4, 32'hAB1C5ED5, 32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174, 32'hE49B69C1, 32'hEFBE4786,
		32'h0FC19DC6, 32'h240CA1CC, 32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7, 32'hC6E00BF3, 32'hD5A79147,
		32'h06CA6351, 32'h14292967, 32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85, 32'hA2BFE8A1, 32'hA81A664B,
		32'hC24B8B70, 32'hC76C51A3, 32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5, 32'h391C0CB3, 32'h4ED8AA4A,
		32'h5B9CCA4F, 32'h682E6FF3, 32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2};

	localparam logic [31:0] START_HASH [8] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19};

	task automatic clear_hash();
		hash_state = START_HASH;
		foreach (msg_block[i]) msg_block[i] = 8'h00;
		block_fill = 0;
		msg_bytes = '0;
		hash_done = 1'b0;
	endtask

	task automatic fold_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = w[i-16] + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
				+ (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
		v = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hash_state[i] += v[i];
	endtask

	task automatic push_error(input logic [1:0] code);
		digest_beat_t b;
		b = '{word: '0, index: '0, last: 1'b1, status: code};
		pending_beats.push_back(b);
	endtask

	// Work out the words that one accepted transaction must produce.
	task automatic predict_hash(input logic [1:0] mode, input logic [7:0] data);
		logic [63:0] bit_len;
		int unsigned pos;
		digest_beat_t b;
		if (mode == MODE_RESTART) begin
			clear_hash();
		end else if (mode == MODE_DATA || mode == MODE_FINISH) begin
			if (hash_done) begin
				push_error(STATUS_FINISHED);
			end else if (mode == MODE_DATA) begin
				if (msg_bytes == '1) begin
					push_error(STATUS_OVERFLOW);
				end else begin
					msg_bytes++;
					msg_block[block_fill] = data;
					block_fill++;
					if (block_fill == 64) begin
						fold_block();
						foreach (msg_block[i]) msg_block[i] = 8'h00;
						block_fill = 0;
					end
				end
			end else begin
				bit_len = {msg_bytes, 3'b000};
				pos = block_fill;
				msg_block[pos] = PAD_MARK;
				pos++;
				if (pos > LEN_POS) begin
					for (int i = pos; i < 64; i++) msg_block[i] = 8'h00;
					fold_block();
					pos = 0;
				end
				for (int i = pos; i < 56; i++) msg_block[i] = 8'h00;
				for (int i = 0; i < 8; i++) msg_block[63-i] = bit_len[8*i +: 8];
				fold_block();
				for (int i = 0; i < 8; i++) begin
					b = '{word: hash_state[i], index: 3'(i), last: (i == 7),
						status: STATUS_OK};
					pending_beats.push_back(b);
				end
				hash_done = 1'b1;
				foreach (msg_block[i]) msg_block[i] = 8'h00;
				block_fill = 0;
			end
		end
	endtask

	// Hold valid across back-to-back transactions; drop it only for a gap.
	task automatic send_item(input logic [1:0] mode, input logic [7:0] data);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= data;
		do @(posedge clk); while (!s_tready);
		predict_hash(mode, data);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_beats.size() != 0) @(posedge clk);
	endtask

	task automatic add_row(input logic [1:0] mode, input logic [7:0] data,
			input bit has_word = 0, input logic [31:0] word0 = '0,
			input logic [1:0] status0 = STATUS_OK);
		stim_row_t r;
		r = '{mode: mode, data: data, has_word: has_word, word0: word0, status0: status0};
		directed_rows.push_back(r);
	endtask

	// Output side: random back-pressure and field-by-field comparison.
	initial begin
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			int stall;
			digest_beat_t want;
			stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h idx %0d status %0d",
						m_tdata[31:0], m_tdata[34:32], m_tuser);
			end else begin
				want = pending_beats.pop_front();
				if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.index ||
						m_tdata[39:35] !== 5'b0 || m_tlast !== want.last ||
						m_tuser !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
							want.word, want.index, want.last, want.status,
							m_tdata[31:0], m_tdata[34:32], m_tlast, m_tuser);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int n_rand;
		int run_len;
		digest_beat_t first;
		mismatches = 0;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = 8'h00;
		s_tuser  = MODE_DATA;
		clear_hash();

		// empty message digest, then finished errors, restart, "abc", odd mode
		add_row(MODE_FINISH, 8'h00, 1, 32'hE3B0C442, STATUS_OK);
		add_row(MODE_DATA, 8'hFF, 1, 32'h0, STATUS_FINISHED);
		add_row(MODE_FINISH, 8'h00, 1, 32'h0, STATUS_FINISHED);
		add_row(MODE_RESTART, 8'h00);
		add_row(MODE_DATA, 8'h61);
		add_row(MODE_DATA, 8'h62);
		add_row(MODE_DATA, 8'h63);
		add_row(MODE_SPARE, 8'hAA);
		add_row(MODE_FINISH, 8'h00, 1, 32'hBA7816BF, STATUS_OK);
		add_row(MODE_RESTART, 8'hFF);
		add_row(MODE_DATA, 8'h00);
		add_row(MODE_DATA, 8'hFF);
		add_row(MODE_FINISH, 8'h00);
		add_row(MODE_RESTART, 8'h00);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].has_word) begin
				wait_drained();
				send_item(directed_rows[i].mode, directed_rows[i].data);
				first = pending_beats[0];
				if (first.word !== directed_rows[i].word0 ||
						first.status !== directed_rows[i].status0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("predictor disagrees with known value %h",
							directed_rows[i].word0);
				end
			end else begin
				send_item(directed_rows[i].mode, directed_rows[i].data);
			end
		end

		// 56 bytes push the length into a second padding block; 63 leave room
		// for the marker only
		for (int k = 0; k < 2; k++) begin
			run_len = (k == 0) ? 56 : 63;
			for (int j = 0; j < run_len; j++) send_item(MODE_DATA, 8'($urandom));
			send_item(MODE_FINISH, 8'($urandom));
			send_item(MODE_RESTART, 8'($urandom));
		end

		// random messages, mostly short, with the odd stray transaction
		n_rand = 0;
		while (n_rand < 24) begin
			run_len = $urandom_range(0, 4) == 0 ? $urandom_range(60, 70) : $urandom_range(0, 8);
			for (int j = 0; j < run_len; j++) begin
				send_item($urandom_range(0, 19) == 0 ? MODE_SPARE : MODE_DATA, 8'($urandom));
				n_rand++;
			end
			if ($urandom_range(0, 5) != 0) send_item(MODE_FINISH, 8'($urandom));
			if ($urandom_range(0, 4) == 0) send_item(MODE_DATA, 8'($urandom));
			if ($urandom_range(0, 3) == 0) wait_drained();
			send_item(MODE_RESTART, 8'($urandom));
			n_rand += 2;
		end

		wait_drained();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/sha_pkg.sv
rtl/sha_ctrl.sv
rtl/sha_datapath.sv
rtl/sha256_stream_hasher_core.sv
rtl/sha_checker.sv
test/sha256_stream_hasher_core_tb.sv
